// ===== hw/rtl/clq_pkg.sv =====
package clq_pkg;

    localparam int POS_W = 16;
    localparam int CAP_W = POS_W + 1;
    localparam int RUN_W = 5;
    localparam int CNT_W = RUN_W + 1;

    localparam int DEF_MAX_RUN      = 31;
    localparam int DEF_MAX_CAPACITY = 65536;
    localparam int CAP_RESET        = 8192;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_NUL       = 8'h00;

    typedef enum logic [1:0] {
        MODE_BYTE     = 2'd0,
        MODE_END_ARG  = 2'd1,
        MODE_END_LINE = 2'd2,
        MODE_NONE     = 2'd3
    } t_mode;

    typedef struct packed {
        logic             in_arg;
        logic             no_arg_yet;
        logic             sep_done;
        logic [RUN_W-1:0] run;
        logic [CNT_W-1:0] cnt;
        logic [POS_W-1:0] wp;
        logic             overflowed;
        logic             run_too_long;
    } t_line_state;

    localparam t_line_state LINE_RESET = '{
        in_arg:       1'b0,
        no_arg_yet:   1'b1,
        sep_done:     1'b0,
        run:          '0,
        cnt:          '0,
        wp:           '0,
        overflowed:   1'b0,
        run_too_long: 1'b0
    };

    typedef struct packed {
        logic [7:0]       out_byte;
        logic [POS_W-1:0] out_position;
        logic             stored;
        logic             is_last;
        logic             is_final;
        logic             line_ok;
    } t_result;

    typedef struct packed {
        logic    emit;
        logic    done;
        t_result res;
    } t_step;

endpackage

// ===== hw/rtl/clq_step.sv =====
module clq_step #(
    parameter int MAX_RUN = clq_pkg::DEF_MAX_RUN
) (
    input  clq_pkg::t_line_state       i_state,
    input  logic [1:0]                 i_mode,
    input  logic [7:0]                 i_char,
    input  logic [clq_pkg::CAP_W-1:0]  i_cap,
    output clq_pkg::t_line_state       o_next,
    output clq_pkg::t_step             o_step
);
    import clq_pkg::*;

    t_mode            mode;
    logic             put;
    logic             fits;
    logic             ok;
    logic [CNT_W-1:0] target;
    logic [CAP_W-1:0] wp_inc;

    assign mode   = t_mode'(i_mode);
    assign wp_inc = {1'b0, i_state.wp} + CAP_W'(1);
    assign fits   = wp_inc < i_cap;
    assign ok     = !i_state.overflowed && !i_state.run_too_long;

    // backslashes owed before the closing byte of this item
    always_comb begin
        target = {1'b0, i_state.run};
        if (mode == MODE_BYTE && i_char == CHAR_QUOTE) begin
            target = {i_state.run, 1'b1};
        end else if (mode != MODE_BYTE) begin
            target = {i_state.run, 1'b0};
        end
    end

    always_comb begin
        o_next = i_state;
        o_step = '0;
        put    = 1'b0;
        unique case (mode) inside
            MODE_BYTE, MODE_END_ARG: begin
                if (!i_state.in_arg) begin
                    o_step.emit = 1'b1;
                    put         = 1'b1;
                    if (!i_state.no_arg_yet && !i_state.sep_done) begin
                        o_step.res.out_byte = CHAR_SPACE;
                        o_next.sep_done     = 1'b1;
                    end else begin
                        o_step.res.out_byte = CHAR_QUOTE;
                        o_next.sep_done     = 1'b0;
                        o_next.no_arg_yet   = 1'b0;
                        o_next.in_arg       = 1'b1;
                        o_next.run          = '0;
                        o_next.cnt          = '0;
                        // an opening backslash only starts the run
                        if (mode == MODE_BYTE && i_char == CHAR_BACKSLASH) begin
                            o_next.run         = RUN_W'(1);
                            o_step.res.is_last = 1'b1;
                            o_step.done        = 1'b1;
                        end
                    end
                end else if (mode == MODE_BYTE && i_char == CHAR_BACKSLASH) begin
                    o_step.done = 1'b1;
                    if (i_state.run < RUN_W'(MAX_RUN)) begin
                        o_next.run = i_state.run + RUN_W'(1);
                    end else begin
                        o_next.run_too_long = 1'b1;
                    end
                end else if (i_state.cnt < target) begin
                    o_step.emit         = 1'b1;
                    put                 = 1'b1;
                    o_step.res.out_byte = CHAR_BACKSLASH;
                    o_next.cnt          = i_state.cnt + CNT_W'(1);
                end else begin
                    o_step.emit         = 1'b1;
                    put                 = 1'b1;
                    o_step.res.out_byte = (mode == MODE_BYTE) ? i_char : CHAR_QUOTE;
                    o_step.res.is_last  = 1'b1;
                    o_step.done         = 1'b1;
                    o_next.cnt          = '0;
                    o_next.run          = '0;
                    if (mode == MODE_END_ARG) begin
                        o_next.in_arg = 1'b0;
                    end
                end
            end
            MODE_END_LINE: begin
                o_step.emit = 1'b1;
                if (i_state.in_arg) begin
                    put = 1'b1;
                    if (i_state.cnt < target) begin
                        o_step.res.out_byte = CHAR_BACKSLASH;
                        o_next.cnt          = i_state.cnt + CNT_W'(1);
                    end else begin
                        o_step.res.out_byte = CHAR_QUOTE;
                        o_next.cnt          = '0;
                        o_next.run          = '0;
                        o_next.in_arg       = 1'b0;
                    end
                end else begin
                    // terminator, then the line starts afresh
                    o_step.res.out_byte     = CHAR_NUL;
                    o_step.res.out_position = ok ? i_state.wp : '0;
                    o_step.res.stored       = 1'b1;
                    o_step.res.is_last      = 1'b1;
                    o_step.res.is_final     = 1'b1;
                    o_step.res.line_ok      = ok;
                    o_step.done             = 1'b1;
                    o_next                  = '0;
                    o_next.no_arg_yet       = 1'b1;
                end
            end
            MODE_NONE: begin
                o_step.done = 1'b1;
            end
        endcase

        if (put) begin
            o_step.res.out_position = i_state.wp;
            o_step.res.stored       = fits;
            if (fits) begin
                o_next.wp = wp_inc[POS_W-1:0];
            end else begin
                o_next.overflowed = 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/command_line_argument_quoter.sv =====
// channel | direction | handshake                 | payload
// input   | in        | i_in_valid / o_in_ready   | i_mode, i_char_byte
// output  | out       | o_out_valid / i_out_ready | o_out_byte .. o_line_ok
// config  | in        | i_cfg_wr_en               | i_cfg_wr_data (buffer capacity)
//
// one result byte per cycle while the output register is not stalled; an item causes
// 1 to 64 results, or none
// the item register holds an item while its backslash run is expanded; a new
// item is taken in the cycle its last result moves into the output register
// synchronous active-low reset clears the line state and sets capacity to 8192 (or MAX_CAPACITY if smaller)
// a stalled output register holds the item register and, while an item is held, stops input transfers
module command_line_argument_quoter #(
    parameter int MAX_RUN      = clq_pkg::DEF_MAX_RUN,
    parameter int MAX_CAPACITY = clq_pkg::DEF_MAX_CAPACITY
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_mode,
    input  logic [7:0]                  i_char_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [7:0]                  o_out_byte,
    output logic [clq_pkg::POS_W-1:0]   o_out_position,
    output logic                        o_stored,
    output logic                        o_is_last,
    output logic                        o_is_final,
    output logic                        o_line_ok,
    input  logic                        i_cfg_wr_en,
    input  logic [clq_pkg::CAP_W-1:0]   i_cfg_wr_data
);
    import clq_pkg::*;

    localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(MAX_CAPACITY);
    localparam logic [CAP_W-1:0] CAP_INIT  =
        (CAP_RESET > MAX_CAPACITY) ? CAP_W'(MAX_CAPACITY) : CAP_W'(CAP_RESET);

    logic             r_item_valid;
    logic [1:0]       r_mode;
    logic [7:0]       r_char;
    t_line_state      r_state;
    t_line_state      n_state;
    logic [CAP_W-1:0] r_cap;
    logic             r_out_valid;
    t_result          r_out;
    t_step            step;
    logic             out_free;
    logic             advance;
    logic             in_xfer;

    clq_step #(
        .MAX_RUN (MAX_RUN)
    ) u_step (
        .i_state (r_state),
        .i_mode  (r_mode),
        .i_char  (r_char),
        .i_cap   (r_cap),
        .o_next  (n_state),
        .o_step  (step)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_item_valid && out_free;
    assign o_in_ready = !r_item_valid || (advance && step.done);
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_INIT;
        end else if (i_cfg_wr_en) begin
            r_cap <= (i_cfg_wr_data > CAP_LIMIT) ? CAP_LIMIT : i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_state      <= LINE_RESET;
        end else begin
            if (in_xfer) begin
                r_item_valid <= 1'b1;
            end else if (advance && step.done) begin
                r_item_valid <= 1'b0;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_mode <= i_mode;
            r_char <= i_char_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && step.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step.emit) begin
            r_out <= step.res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out.out_byte;
    assign o_out_position = r_out.out_position;
    assign o_stored       = r_out.stored;
    assign o_is_last      = r_out.is_last;
    assign o_is_final     = r_out.is_final;
    assign o_line_ok      = r_out.line_ok;

    a_final_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_final |-> o_is_last && o_stored)
        else $error("terminator not marked last and stored");

    a_ok_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_ok |-> o_is_final)
        else $error("line ok outside terminator");

    a_line_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && step.emit && step.res.is_final
        |=> r_state.wp == '0 && r_state.no_arg_yet && !r_state.in_arg)
        else $error("line state not cleared after terminator");

    a_pos_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && step.emit && step.res.stored && !step.res.is_final
        |=> r_state.wp == $past(r_state.wp) + POS_W'(1))
        else $error("write position did not step on stored byte");

endmodule
